[rtl/assert_macros.svh]
// Assertion macros shared by the blink sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define LBPS_ASSERT_SAME(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("sequencer check failed in same cycle");

// Check that a condition implies another in the next cycle.
`define LBPS_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("sequencer check failed in next cycle");

`endif

[rtl/lbps_pkg.sv]
// Types, constants and the blink pattern ROM of the LED blink sequencer.
package lbps_pkg;

  localparam int ROM_PATTERNS = 17;
  localparam int ROM_ROWS     = 12;

  localparam logic [7:0] MARK_WRAP    = 8'hff;
  localparam logic [7:0] MARK_ONESHOT = 8'hfe;
  localparam logic [7:0] HOLD_UNIT    = 8'd5;
  localparam logic [4:0] PATTERN_ALL_OFF = 5'd10;

  typedef struct packed {
    logic [7:0] level;
    logic [7:0] hold;
  } rom_row_t;

  typedef struct packed {
    logic       pattern_valid;
    logic [4:0] pattern_number;
  } item_t;

  typedef struct packed {
    logic       led_level;
    logic [4:0] active_pattern;
  } result_t;

  localparam rom_row_t ROW_WRAP = '{level: MARK_WRAP, hold: MARK_WRAP};
  localparam rom_row_t ROW_ZERO = '{level: 8'd0, hold: 8'd0};

  function automatic rom_row_t mk_row(logic [7:0] level, logic [7:0] hold);
    rom_row_t r;
    r.level = level;
    r.hold  = hold;
    return r;
  endfunction

  // Blink ROM: patterns 0..9 are five short/long blinks and a gap,
  // patterns 10..16 list rows, wrap marks to row 5; the rest reads as zero.
  function automatic rom_row_t rom_read(logic [4:0] pat, logic [3:0] row);
    rom_row_t   r;
    logic [2:0] blink;
    logic       long_blink;
    r          = ROW_ZERO;
    blink      = 3'(row >> 1);
    long_blink = 1'b0;
    if (pat < 5'(ROM_PATTERNS) && row < 4'(ROM_ROWS)) begin
      if (pat < PATTERN_ALL_OFF) begin
        if (pat <= 5'd5) begin
          long_blink = ({2'b00, blink} >= pat);
        end else begin
          long_blink = ({2'b00, blink} < (pat - 5'd5));
        end
        if (row == 4'd11) begin
          r = ROW_WRAP;
        end else if (row == 4'd10) begin
          r = mk_row(8'd0, HOLD_UNIT * 8'd2);
        end else if (row[0]) begin
          r = mk_row(8'd0, HOLD_UNIT);
        end else begin
          r = mk_row(8'd1, long_blink ? HOLD_UNIT * 8'd3 : HOLD_UNIT);
        end
      end else begin
        r = (row < 4'd6) ? ROW_WRAP : ROW_ZERO;
        case (pat)
          5'd10: if (row == 4'd0) r = mk_row(8'd0, 8'd1);
          5'd11: if (row == 4'd0) r = mk_row(8'd1, 8'd1);
          5'd12: begin
            if (row == 4'd0) r = mk_row(8'd1, 8'd1);
            if (row == 4'd1) r = mk_row(8'd0, 8'd199);
          end
          5'd13: begin
            if (row == 4'd0) r = mk_row(8'd1, 8'd1);
            if (row == 4'd1) r = mk_row(8'd0, 8'd99);
          end
          5'd14: begin
            if (row == 4'd0) r = mk_row(8'd1, 8'd12);
            if (row == 4'd1) r = mk_row(8'd0, 8'd12);
          end
          5'd15: begin
            if (row == 4'd0) r = mk_row(8'd1, 8'd4);
            if (row == 4'd1) r = mk_row(8'd0, 8'd1);
            if (row == 4'd2) r = mk_row(MARK_ONESHOT, MARK_ONESHOT);
          end
          5'd16: begin
            if (row == 4'd0) r = mk_row(8'd1, 8'd1);
            if (row == 4'd1) r = mk_row(8'd0, 8'd9);
            if (row == 4'd2) r = mk_row(8'd1, 8'd1);
            if (row == 4'd3) r = mk_row(8'd0, 8'd89);
          end
          default: r = ROW_ZERO;
        endcase
      end
    end
    return r;
  endfunction

endpackage

[rtl/lbps_if.sv]
// Handshake channels of the blink sequencer: tick input and LED result.
interface lbps_in_if;
  logic       valid;
  logic       ready;
  logic       pattern_valid;
  logic [4:0] pattern_number;

  modport source (output valid, output pattern_valid, output pattern_number, input ready);
  modport sink (input valid, input pattern_valid, input pattern_number, output ready);
endinterface

interface lbps_out_if;
  logic       valid;
  logic       ready;
  logic       led_level;
  logic [4:0] active_pattern;

  modport source (output valid, output led_level, output active_pattern, input ready);
  modport sink (input valid, input led_level, input active_pattern, output ready);
endinterface

[rtl/led_blink_pattern_sequencer_top.sv]
// LED blink pattern sequencer: one tick beat in, one LED level beat out.
//
// in_ch carries one beat per tick: pattern_valid and pattern_number. A valid
// number below PATTERN_COUNT that differs from the running pattern restarts
// playback at row 0 of that pattern; other numbers are ignored.
// out_ch returns one beat per tick: led_level (1 lit) and active_pattern.
// An accepted tick lands in the input register; once the result register
// can load, it is processed and its result is held on out_ch until taken.
// Throughput: one tick per cycle while out_ch.ready is high; the ROM
// lookup, row advance and hold countdown are a single pass between the
// input and result registers.
// Reset: pattern 10 (all off), row 0, hold 0; both channels empty.
// Stall: when out_ch.ready is low the result register holds its beat, the
// input register holds one more tick, and in_ch.ready drops only when both
// are full.
`include "assert_macros.svh"

module led_blink_pattern_sequencer_top #(
  parameter int ROWS_PER_PATTERN = 12,
  parameter int PATTERN_COUNT    = 17
) (
  input  logic        clk,
  input  logic        rst,
  lbps_in_if.sink     in_ch,
  lbps_out_if.source  out_ch
);

  logic              item_valid;
  lbps_pkg::item_t   item;
  lbps_pkg::result_t res;
  logic              can_load;
  logic              take;

  assign take = item_valid && can_load;

  lbps_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  lbps_seq #(
    .ROWS_PER_PATTERN (ROWS_PER_PATTERN),
    .PATTERN_COUNT    (PATTERN_COUNT)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .item (item),
    .res  (res)
  );

  lbps_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  `LBPS_ASSERT_NEXT(a_take_gives_result, take, out_ch.valid)
  `LBPS_ASSERT_NEXT(a_item_kept_on_stall, item_valid && !take, item_valid)
  `LBPS_ASSERT_SAME(a_pattern_in_range, out_ch.valid, out_ch.active_pattern < PATTERN_COUNT)

endmodule

[rtl/lbps_in_reg.sv]
// Input register of the blink sequencer: holds one tick beat until consumed.
module lbps_in_reg (
  input  logic                clk,
  input  logic                rst,
  lbps_in_if.sink             in_ch,
  input  logic                take,
  output logic                item_valid,
  output lbps_pkg::item_t     item
);

  logic accept;

  assign in_ch.ready = !item_valid || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.pattern_valid  <= in_ch.pattern_valid;
      item.pattern_number <= in_ch.pattern_number;
    end
  end

endmodule

[rtl/lbps_seq.sv]
// Pattern sequencer state: pattern select, row advance, hold countdown.
module lbps_seq #(
  parameter int ROWS_PER_PATTERN = 12,
  parameter int PATTERN_COUNT    = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  lbps_pkg::item_t   item,
  output lbps_pkg::result_t res
);

  localparam logic [5:0] PAT_LIMIT = 6'(PATTERN_COUNT);
  localparam logic [4:0] ROW_LIMIT = 5'(ROWS_PER_PATTERN);

  logic [4:0] pattern, pattern_next;
  logic [3:0] row, row_next;
  logic [7:0] hold, hold_next;

  logic       change;
  logic [4:0] pat1;
  logic [3:0] row1, row_adv;
  logic [7:0] hold1;
  lbps_pkg::rom_row_t entry_adv, entry_out;
  lbps_pkg::rom_row_t entry_req, entry_first;

  function automatic lbps_pkg::rom_row_t read_row(logic [4:0] pat, logic [3:0] r);
    lbps_pkg::rom_row_t e;
    if ({1'b0, r} >= ROW_LIMIT) begin
      e = lbps_pkg::ROW_WRAP;
    end else begin
      e = lbps_pkg::rom_read(pat, r);
    end
    return e;
  endfunction

  always_comb begin
    change = item.pattern_valid && ({1'b0, item.pattern_number} < PAT_LIMIT) &&
             (item.pattern_number != pattern);
    entry_req = read_row(item.pattern_number, 4'd0);
    pat1  = change ? item.pattern_number : pattern;
    row1  = change ? 4'd0 : row;
    hold1 = change ? entry_req.hold : hold;

    row_adv     = row1 + 4'd1;
    entry_adv   = read_row(pat1, row_adv);
    entry_first = read_row(pat1, 4'd0);

    pattern_next = pat1;
    row_next     = row1;
    hold_next    = hold1 - 8'd1;
    if (hold1 == 8'd0) begin
      if (entry_adv.level == lbps_pkg::MARK_WRAP) begin
        row_next  = 4'd0;
        hold_next = entry_first.hold;
      end else if (entry_adv.level == lbps_pkg::MARK_ONESHOT) begin
        pattern_next = lbps_pkg::PATTERN_ALL_OFF;
        row_next     = 4'd0;
        hold_next    = 8'd0;
      end else begin
        row_next  = row_adv;
        hold_next = entry_adv.hold;
      end
    end

    entry_out          = read_row(pattern_next, row_next);
    res.led_level      = (entry_out.level != 8'd0);
    res.active_pattern = pattern_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= lbps_pkg::PATTERN_ALL_OFF;
      row     <= 4'd0;
      hold    <= 8'd0;
    end else if (step) begin
      pattern <= pattern_next;
      row     <= row_next;
      hold    <= hold_next;
    end
  end

endmodule

[rtl/lbps_out_reg.sv]
// Result register of the blink sequencer: holds one result beat for the receiver.
module lbps_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  lbps_pkg::result_t res,
  output logic              can_load,
  lbps_out_if.source        out_ch
);

  assign can_load = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.led_level      <= res.led_level;
      out_ch.active_pattern <= res.active_pattern;
    end
  end

endmodule
